/* rtl/assert_macros.svh */
// Assertion helper macros for the decimal formatter RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

/* rtl/i2da_pkg.sv */
// Shared types and constants for the 64-bit decimal ASCII formatter.
// No dependencies.
`default_nettype none

package i2da_pkg;

  localparam int unsigned ValW     = 64;
  localparam int unsigned NumDigits = 20;
  localparam int unsigned BcdW     = 4 * NumDigits;
  localparam int unsigned DigCntW  = $clog2(NumDigits + 1);
  localparam int unsigned BitCntW  = $clog2(ValW);
  localparam int unsigned CharW    = 6;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [CharW-1:0] CharZero  = 6'd48;
  localparam logic [CharW-1:0] CharMinus = 6'd45;

  // Classified word: magnitude and sign
  typedef struct packed {
    logic [ValW-1:0] mag;
    logic            neg;
  } job_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

/* rtl/int64_to_decimal_ascii_core.sv */
// Top level of the 64-bit decimal ASCII formatter: front end, queue, back end.
// Depends on i2da_pkg, i2da_front, i2da_queue, i2da_back and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// A word is taken when start is high and busy is low. Its decimal text
// comes out one character per out_valid_o pulse, most significant first,
// with last_char_o on the final character; the receiver must take every
// character in the cycle it is shown. The back end loads the word, runs a
// shift-and-add-3 conversion over all 64 bits, strips leading zeros while
// keeping at least one digit, and then emits one character per cycle ('-'
// first if negative, then the digits). Ahead of the back end a word is
// held in the front stage register and then in the queue. The front stage
// and a two-word queue take up to three further words while one is being
// converted.
module int64_to_decimal_ascii_core import i2da_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [ValW-1:0]  raw_value_i,
  input  wire logic             interpret_signed_i,
  output logic                  out_valid_o,
  output logic [CharW-1:0]      ascii_char_o,
  output logic                  last_char_o
);

  q_stat_t q_stat;
  job_t    fe_job, q_job;
  logic    push, pop;

  // Front end: accept and classify
  i2da_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .raw_value_i        (raw_value_i),
    .interpret_signed_i (interpret_signed_i),
    .q_stat_i           (q_stat),
    .push_o             (push),
    .job_o              (fe_job)
  );

  // Queue between the two halves
  i2da_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (fe_job),
    .pop_i  (pop),
    .job_o  (q_job),
    .stat_o (q_stat)
  );

  // Back end: convert and emit
  i2da_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (q_job),
    .job_valid_i  (!q_stat.empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .ascii_char_o (ascii_char_o),
    .last_char_o  (last_char_o)
  );

  // Checks
  `ASSERT_NEVER(a_q_no_overflow, push && q_stat.full)
  `ASSERT_NEVER(a_q_no_underflow, pop && q_stat.empty)
  `ASSERT_AT(a_gap_after_last, (out_valid_o && last_char_o) |=> !out_valid_o)

endmodule

`default_nettype wire

/* rtl/i2da_front.sv */
// Front end: takes a word, works out its sign and magnitude, hands it to the queue.
// Depends on i2da_pkg.
`default_nettype none

module i2da_front import i2da_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic [ValW-1:0] raw_value_i,
  input  wire logic            interpret_signed_i,
  input  wire q_stat_t         q_stat_i,
  output logic                 push_o,
  output job_t                 job_o
);

  logic valid_q, valid_d;
  job_t job_q, job_d;
  logic accept, neg;

  // Hold stage stalls only when queue is full
  assign busy   = valid_q && q_stat_i.full;
  assign accept = start && !busy;
  assign push_o = valid_q && !q_stat_i.full;
  assign job_o  = job_q;

  // Classify: negative only in signed mode with the top bit set
  always_comb begin
    neg       = interpret_signed_i && raw_value_i[ValW-1];
    job_d.neg = neg;
    job_d.mag = neg ? (~raw_value_i + {{(ValW-1){1'b0}}, 1'b1}) : raw_value_i;
    valid_d   = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= job_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/i2da_queue.sv */
// Short word queue between front and back end.
// Depends on i2da_pkg.
`default_nettype none

module i2da_queue import i2da_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  input  wire logic pop_i,
  output job_t      job_o,
  output q_stat_t   stat_o
);

  job_t             entry_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign job_o        = entry_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/i2da_back.sv */
// Back end: shift-and-add-3 binary to BCD, then emits sign and digits MSB first.
// Depends on i2da_pkg.
`default_nettype none

module i2da_back import i2da_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire job_t       job_i,
  input  wire logic       job_valid_i,
  output logic            pop_o,
  output logic            out_valid_o,
  output logic [CharW-1:0] ascii_char_o,
  output logic            last_char_o
);

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StSkip,
    StSign,
    StDigit
  } state_e;

  state_e             state_q;
  logic [ValW-1:0]    bin_q;
  logic [BcdW-1:0]    bcd_q;
  logic [BcdW-1:0]    bcd_adj;
  logic               neg_q;
  logic [BitCntW-1:0] bit_cnt_q;
  logic [DigCntW-1:0] dig_left_q;
  logic [3:0]         top_dig;
  logic               out_valid_q, last_q;
  logic [CharW-1:0]   char_q;

  assign pop_o        = (state_q == StIdle) && job_valid_i;
  assign out_valid_o  = out_valid_q;
  assign ascii_char_o = char_q;
  assign last_char_o  = last_q;
  assign top_dig      = bcd_q[BcdW-1 -: 4];

  // Add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                      : bcd_q[4*i +: 4];
    end
  end

  // Sequencer with registered character outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bin_q       <= '0;
      bcd_q       <= '0;
      neg_q       <= 1'b0;
      bit_cnt_q   <= '0;
      dig_left_q  <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      char_q      <= '0;
    end else begin
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            bin_q     <= job_i.mag;
            neg_q     <= job_i.neg;
            bcd_q     <= '0;
            bit_cnt_q <= '0;
            state_q   <= StConv;
          end
        end
        StConv: begin
          bcd_q     <= {bcd_adj[BcdW-2:0], bin_q[ValW-1]};
          bin_q     <= {bin_q[ValW-2:0], 1'b0};
          bit_cnt_q <= bit_cnt_q + 1'b1;
          if (bit_cnt_q == BitCntW'(ValW - 1)) begin
            dig_left_q <= DigCntW'(NumDigits);
            state_q    <= StSkip;
          end
        end
        StSkip: begin
          // drop leading zeros, keeping at least one digit
          if (top_dig == 4'd0 && dig_left_q != DigCntW'(1)) begin
            bcd_q      <= {bcd_q[BcdW-5:0], 4'd0};
            dig_left_q <= dig_left_q - 1'b1;
          end else begin
            state_q <= neg_q ? StSign : StDigit;
          end
        end
        StSign: begin
          out_valid_q <= 1'b1;
          char_q      <= CharMinus;
          state_q     <= StDigit;
        end
        StDigit: begin
          out_valid_q <= 1'b1;
          char_q      <= CharZero + {{(CharW-4){1'b0}}, top_dig};
          last_q      <= (dig_left_q == DigCntW'(1));
          bcd_q       <= {bcd_q[BcdW-5:0], 4'd0};
          dig_left_q  <= dig_left_q - 1'b1;
          if (dig_left_q == DigCntW'(1)) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
